// File: rtl/bwl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwl_pkg
// Shared types and constants of the brightest window locator.
// ----------------------------------------------------------------------------
package bwl_pkg;

   // Default geometry
   localparam int WINDOW_DEF     = 50;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // Fixed field widths
   localparam int CFG_W      = 11;
   localparam int PIXEL_W    = 8;
   localparam int COORD_W    = 10;
   localparam int COL_SUM_W  = 14;
   localparam int WIN_SUM_W  = 20;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Queue depths
   localparam int MID_DEPTH = 4;
   localparam int RES_DEPTH = 2;
   localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

   // Register map (index taken from address bit 2)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   localparam logic [CFG_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [CFG_W-1:0] IMAGE_HEIGHT_RST = 11'd480;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               frame_start;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [COORD_W-1:0]   corner_x;
      logic [COORD_W-1:0]   corner_y;
      logic [COORD_W-1:0]   centre_x;
      logic [COORD_W-1:0]   centre_y;
      logic [WIN_SUM_W-1:0] window_sum;
   } rsp_type;

   // Candidate window position carried with each pixel
   typedef struct packed {
      logic [COORD_W-1:0] corner_x;
      logic [COORD_W-1:0] corner_y;
      logic [COORD_W-1:0] centre_x;
      logic [COORD_W-1:0] centre_y;
   } coord_type;

   // Classification of one pixel, made by the front part
   typedef struct packed {
      logic frame_start;  // forget the best window before this pixel
      logic row_first;    // first row: column sum restarts
      logic row_sub;      // row at or past WINDOW: drop the oldest pixel
      logic row_act;      // row completes a window column
      logic col_first;    // first column: running sum restarts
      logic col_sub;      // column at or past WINDOW: drop the oldest column
      logic col_act;      // column completes a window
      logic frame_end;    // last pixel of the frame: emit a result
   } flags_type;

endpackage

// File: rtl/bwl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwl_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bwl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/bwl_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwl_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module bwl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the request
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

// File: rtl/bwl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwl_front
// Tracks the raster position, classifies each pixel and queues it.
// ----------------------------------------------------------------------------
module bwl_front #(
   parameter int WINDOW     = bwl_pkg::WINDOW_DEF,
   parameter int MAX_WIDTH  = bwl_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bwl_pkg::MAX_HEIGHT_DEF,
   localparam int XW = $clog2(MAX_WIDTH),
   localparam int YW = $clog2(MAX_HEIGHT),
   localparam int SW = $clog2(WINDOW * MAX_WIDTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bwl_pkg::req_type          req_data,
   output logic                      full,
   input  logic [bwl_pkg::CFG_W-1:0] image_width,
   input  logic [bwl_pkg::CFG_W-1:0] image_height,
   output logic                      head_valid,
   input  logic                      head_pop,
   output bwl_pkg::flags_type        head_flags,
   output logic [bwl_pkg::PIXEL_W-1:0] head_pixel,
   output logic [XW-1:0]             head_x,
   output logic [SW-1:0]             head_slot,
   output bwl_pkg::coord_type        head_coord
);

   import bwl_pkg::*;

   localparam int ITEM_W = $bits(flags_type) + PIXEL_W + XW + SW + $bits(coord_type);
   localparam logic [SW-1:0] BASE_LAST = SW'((WINDOW - 1) * MAX_WIDTH);
   localparam logic [SW-1:0] BASE_STEP = SW'(MAX_WIDTH);

   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [SW-1:0] base_ff, base_in;

   logic          accept;
   logic [XW-1:0] x, wlast;
   logic [YW-1:0] y, hlast;
   logic [SW-1:0] base;
   logic          row_end;
   flags_type     flags;
   coord_type     coord;
   logic [ITEM_W-1:0] item_din, item_dout;
   logic          item_empty;

   assign accept = push && !full;

   // Clamp the configured size to the supported range, as last positions
   always_comb begin
      if (image_width == '0) begin
         wlast = '0;
      end else if (32'(image_width) > MAX_WIDTH) begin
         wlast = XW'(MAX_WIDTH - 1);
      end else begin
         wlast = XW'(image_width - 1'b1);
      end
      if (image_height == '0) begin
         hlast = '0;
      end else if (32'(image_height) > MAX_HEIGHT) begin
         hlast = YW'(MAX_HEIGHT - 1);
      end else begin
         hlast = YW'(image_height - 1'b1);
      end
   end

   // Position of this pixel; a frame start restarts at the origin
   assign x    = req_data.frame_start ? '0 : col_ff;
   assign y    = req_data.frame_start ? '0 : row_ff;
   assign base = req_data.frame_start ? '0 : base_ff;

   assign row_end = (x >= wlast);

   // Classify the pixel
   always_comb begin
      flags.frame_start = req_data.frame_start;
      flags.row_first   = (y == '0);
      flags.row_sub     = (32'(y) >= WINDOW);
      flags.row_act     = (32'(y) >= WINDOW - 1);
      flags.col_first   = (x == '0);
      flags.col_sub     = (32'(x) >= WINDOW);
      flags.col_act     = (32'(x) >= WINDOW - 1);
      flags.frame_end   = row_end && (y >= hlast);
      coord.corner_x    = COORD_W'(32'(x) + 1 - WINDOW);
      coord.corner_y    = COORD_W'(32'(y) + 1 - WINDOW);
      coord.centre_x    = COORD_W'(32'(x) + 1 - WINDOW + WINDOW / 2);
      coord.centre_y    = COORD_W'(32'(y) + 1 - WINDOW + WINDOW / 2);
   end

   // Advance the raster position and the line store row base
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      base_in = base_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            if (flags.frame_end) begin
               row_in  = '0;
               base_in = '0;
            end else begin
               row_in  = y + 1'b1;
               base_in = (base == BASE_LAST) ? '0 : base + BASE_STEP;
            end
         end else begin
            col_in  = x + 1'b1;
            row_in  = y;
            base_in = base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         base_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         base_ff <= base_in;
      end
   end

   // Queue towards the back part
   assign item_din = {flags, req_data.pixel, x, base + SW'(x), coord};

   bwl_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (accept),
      .din   (item_din),
      .full  (full),
      .pop   (head_pop),
      .dout  (item_dout),
      .empty (item_empty)
   );

   assign head_valid = !item_empty;
   assign {head_flags, head_pixel, head_x, head_slot, head_coord} = item_dout;

endmodule

// File: rtl/bwl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwl_back
// Column sums over the line store, horizontal running sum and best window.
// ----------------------------------------------------------------------------
module bwl_back #(
   parameter int WINDOW     = bwl_pkg::WINDOW_DEF,
   parameter int MAX_WIDTH  = bwl_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bwl_pkg::MAX_HEIGHT_DEF,
   localparam int XW = $clog2(MAX_WIDTH),
   localparam int SW = $clog2(WINDOW * MAX_WIDTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        head_valid,
   output logic                        head_pop,
   input  bwl_pkg::flags_type          head_flags,
   input  logic [bwl_pkg::PIXEL_W-1:0] head_pixel,
   input  logic [XW-1:0]               head_x,
   input  logic [SW-1:0]               head_slot,
   input  bwl_pkg::coord_type          head_coord,
   input  logic                        res_taken,
   output logic                        res_push,
   output bwl_pkg::rsp_type            res_data
);

   import bwl_pkg::*;

   // Result space not yet promised to a frame end in flight
   logic [RES_CNT_W-1:0] credits_ff, credits_in;
   logic                 issue;

   // Stage 1: memory data, column sum
   logic                 s1_valid_ff;
   flags_type            s1_flags_ff;
   logic [PIXEL_W-1:0]   s1_pixel_ff;
   logic [XW-1:0]        s1_x_ff;
   logic [SW-1:0]        s1_slot_ff;
   coord_type            s1_coord_ff;
   logic                 fwd_ls_hit_ff, fwd_cs_hit_ff;
   logic [PIXEL_W-1:0]   fwd_ls_ff;
   logic [COL_SUM_W-1:0] fwd_cs_ff;
   logic [XW:0]          fill_ff, fill_in;
   logic [PIXEL_W-1:0]   ls_rdata, ls_old;
   logic [COL_SUM_W-1:0] cs_rdata, cs_old, cs;

   // Stage 2: running sum
   logic                 s2_valid_ff;
   flags_type            s2_flags_ff;
   coord_type            s2_coord_ff;
   logic [COL_SUM_W-1:0] s2_cs_ff;
   logic [WIN_SUM_W-1:0] run_ff, rs;
   logic [COL_SUM_W-1:0] delay_ff [WINDOW];

   // Stage 3: best window
   logic                 s3_valid_ff;
   flags_type            s3_flags_ff;
   coord_type            s3_coord_ff;
   logic [WIN_SUM_W-1:0] s3_rs_ff;
   logic                 best_found_ff, best_found_in;
   logic [WIN_SUM_W-1:0] best_sum_ff, new_sum;
   coord_type            best_coord_ff, new_coord;
   logic                 cur_found, take, new_found;

   // Issue: a frame end leaves only with result space reserved
   assign issue    = head_valid && (!head_flags.frame_end || (credits_ff != '0));
   assign head_pop = issue;

   always_comb begin
      credits_in = credits_ff;
      if (issue && head_flags.frame_end) begin
         credits_in = credits_in - 1'b1;
      end
      if (res_taken) begin
         credits_in = credits_in + 1'b1;
      end
   end

   // Line store: WINDOW rows of pixels
   bwl_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (WINDOW * MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_pixel_ff),
      .rd_en   (issue),
      .rd_addr (head_slot),
      .rd_data (ls_rdata)
   );

   // Column sums, one per image column
   bwl_ram #(
      .WIDTH (COL_SUM_W),
      .DEPTH (MAX_WIDTH)
   ) u_column_sums (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_x_ff),
      .wr_data (cs),
      .rd_en   (issue),
      .rd_addr (head_x),
      .rd_data (cs_rdata)
   );

   // Take the data written in the same cycle as the read; unwritten columns read zero
   assign ls_old = fwd_ls_hit_ff ? fwd_ls_ff : ls_rdata;

   always_comb begin
      if (fwd_cs_hit_ff) begin
         cs_old = fwd_cs_ff;
      end else if ((XW + 1)'(s1_x_ff) < fill_ff) begin
         cs_old = cs_rdata;
      end else begin
         cs_old = '0;
      end
      if (s1_flags_ff.row_first) begin
         cs = COL_SUM_W'(s1_pixel_ff);
      end else begin
         cs = cs_old + COL_SUM_W'(s1_pixel_ff)
              - (s1_flags_ff.row_sub ? COL_SUM_W'(ls_old) : '0);
      end
   end

   // Column sums written so far form a prefix of the columns
   always_comb begin
      fill_in = fill_ff;
      if (s1_valid_ff && ((XW + 1)'(s1_x_ff) >= fill_ff)) begin
         fill_in = (XW + 1)'(s1_x_ff) + 1'b1;
      end
   end

   // Running sum over the last WINDOW column sums of this row
   always_comb begin
      if (s2_flags_ff.col_first) begin
         rs = WIN_SUM_W'(s2_cs_ff);
      end else begin
         rs = run_ff + WIN_SUM_W'(s2_cs_ff)
              - (s2_flags_ff.col_sub ? WIN_SUM_W'(delay_ff[WINDOW-1]) : '0);
      end
   end

   // Compare against the best; a frame start forgets it first
   always_comb begin
      cur_found = s3_flags_ff.frame_start ? 1'b0 : best_found_ff;
      take      = s3_flags_ff.row_act && s3_flags_ff.col_act
                  && (!cur_found || (s3_rs_ff > best_sum_ff));
      new_found = cur_found || take;
      new_sum   = take ? s3_rs_ff : best_sum_ff;
      new_coord = take ? s3_coord_ff : best_coord_ff;
      best_found_in = best_found_ff;
      if (s3_valid_ff) begin
         best_found_in = s3_flags_ff.frame_end ? 1'b0 : new_found;
      end
   end

   // Emit the result on the frame's last pixel
   assign res_push = s3_valid_ff && s3_flags_ff.frame_end;

   always_comb begin
      res_data.found      = new_found;
      res_data.corner_x   = new_found ? new_coord.corner_x : '0;
      res_data.corner_y   = new_found ? new_coord.corner_y : '0;
      res_data.centre_x   = new_found ? new_coord.centre_x : '0;
      res_data.centre_y   = new_found ? new_coord.centre_y : '0;
      res_data.window_sum = new_found ? new_sum : '0;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         credits_ff    <= RES_CNT_W'(RES_DEPTH);
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         fill_ff       <= '0;
         run_ff        <= '0;
         best_found_ff <= 1'b0;
      end else begin
         credits_ff    <= credits_in;
         s1_valid_ff   <= issue;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         fill_ff       <= fill_in;
         if (s2_valid_ff && s2_flags_ff.row_act) begin
            run_ff <= rs;
         end
         best_found_ff <= best_found_in;
      end
   end

   // Stage 1 payload and same-cycle write forwarding
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_flags_ff   <= head_flags;
         s1_pixel_ff   <= head_pixel;
         s1_x_ff       <= head_x;
         s1_slot_ff    <= head_slot;
         s1_coord_ff   <= head_coord;
         fwd_ls_hit_ff <= s1_valid_ff && (s1_slot_ff == head_slot);
         fwd_cs_hit_ff <= s1_valid_ff && (s1_x_ff == head_x);
         fwd_ls_ff     <= s1_pixel_ff;
         fwd_cs_ff     <= cs;
      end
   end

   // Stage 2 and 3 payload
   always_ff @(posedge clock) begin
      s2_flags_ff <= s1_flags_ff;
      s2_coord_ff <= s1_coord_ff;
      s2_cs_ff    <= cs;
      s3_flags_ff <= s2_flags_ff;
      s3_coord_ff <= s2_coord_ff;
      s3_rs_ff    <= rs;
   end

   // Delay line of column sums, newest at the head
   always_ff @(posedge clock) begin
      if (s2_valid_ff && s2_flags_ff.row_act) begin
         delay_ff[0] <= s2_cs_ff;
         for (int i = 1; i < WINDOW; i++) begin
            delay_ff[i] <= delay_ff[i-1];
         end
      end
   end

   // Hold the best window
   always_ff @(posedge clock) begin
      if (s3_valid_ff) begin
         best_sum_ff   <= new_sum;
         best_coord_ff <= new_coord;
      end
   end

endmodule

// File: rtl/brightest_window_locator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brightest_window_locator_core
// Finds the WINDOW by WINDOW pixel window with the greatest sum in each frame.
// ----------------------------------------------------------------------------
//   channel  ports                                   moves
//   req      push, full, req_data                    one pixel per request
//   rsp      empty, pop, rsp_data                    one result per frame
//   csr      psel, penable, pwrite, paddr, pwdata,   image size registers
//            prdata, pready
//
// Takes one pixel per clock while result space is free; the front part, a
// four-entry queue and a three-stage back part (line store and column sum
// RAM reads, running sum, best window compare) overlap successive pixels.
// A frame's last pixel passes the queue and the back stages, then its result is queued.
// Synchronous reset; no clearing pass, unwritten column sums read as zero.
// Two results may wait unread; a frame's last pixel then waits in the queue,
// and full rises once the queue has filled behind it.
// ----------------------------------------------------------------------------
module brightest_window_locator_core #(
   parameter int WINDOW     = bwl_pkg::WINDOW_DEF,
   parameter int MAX_WIDTH  = bwl_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bwl_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  bwl_pkg::req_type                 req_data,
   output logic                             empty,
   input  logic                             pop,
   output bwl_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [bwl_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [bwl_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [bwl_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   import bwl_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int SW = $clog2(WINDOW * MAX_WIDTH);

   logic [CFG_W-1:0]   image_width_ff, image_height_ff;
   logic               csr_write;
   logic               head_valid, head_pop;
   flags_type          head_flags;
   logic [PIXEL_W-1:0] head_pixel;
   logic [XW-1:0]      head_x;
   logic [SW-1:0]      head_slot;
   coord_type          head_coord;
   logic               res_push, res_full, res_taken;
   rsp_type            res_data;
   logic [$bits(rsp_type)-1:0] res_dout;

   // Configuration registers
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RST;
         image_height_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_write) begin
         case (paddr[2])
            REG_IMAGE_WIDTH: begin
               image_width_ff <= pwdata[CFG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               image_height_ff <= pwdata[CFG_W-1:0];
            end
            default: begin
               image_width_ff <= image_width_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(image_height_ff);
         default:          prdata = '0;
      endcase
   end

   // Front: position tracking, classification, queue
   bwl_front #(
      .WINDOW     (WINDOW),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .req_data     (req_data),
      .full         (full),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .head_valid   (head_valid),
      .head_pop     (head_pop),
      .head_flags   (head_flags),
      .head_pixel   (head_pixel),
      .head_x       (head_x),
      .head_slot    (head_slot),
      .head_coord   (head_coord)
   );

   // Back: sums and best window
   bwl_back #(
      .WINDOW     (WINDOW),
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_flags (head_flags),
      .head_pixel (head_pixel),
      .head_x     (head_x),
      .head_slot  (head_slot),
      .head_coord (head_coord),
      .res_taken  (res_taken),
      .res_push   (res_push),
      .res_data   (res_data)
   );

   // Result queue
   assign res_taken = pop && !empty;

   bwl_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RES_DEPTH)
   ) u_res_queue (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .din   (res_data),
      .full  (res_full),
      .pop   (pop),
      .dout  (res_dout),
      .empty (empty)
   );

   assign rsp_data = rsp_type'(res_dout);

   // Checks
   a_res_room: assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("result pushed into a full result queue");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.found) |->
         (rsp_data.window_sum == '0 && rsp_data.corner_x == '0 &&
          rsp_data.corner_y == '0 && rsp_data.centre_x == '0 &&
          rsp_data.centre_y == '0))
      else $error("result without a window carries non-zero fields");

   a_centre: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.found) |->
         (rsp_data.centre_x == COORD_W'(rsp_data.corner_x + COORD_W'(WINDOW / 2)) &&
          rsp_data.centre_y == COORD_W'(rsp_data.corner_y + COORD_W'(WINDOW / 2))))
      else $error("window centre does not match its corner");

endmodule

// File: bench/tb_brightest_window_locator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_brightest_window_locator_core
// Self-checking bench for the brightest window locator core.
// Pixels are sent as requests through the input queue. A local tracker keeps
// its own line store, column sums and running sum, and queues one expected
// frame result for every completed frame. Results are popped with random
// stalls and compared field by field. Image size registers are written over
// the CSR port only while the core is idle, and read back each time.
// ----------------------------------------------------------------------------
module tb_brightest_window_locator_core;
   import bwl_pkg::*;

   localparam int WINDOW     = WINDOW_DEF;
   localparam int MAX_WIDTH  = MAX_WIDTH_DEF;
   localparam int MAX_HEIGHT = MAX_HEIGHT_DEF;

   typedef enum int {
      FILL_NOISE,
      FILL_FLAT,
      FILL_DIM,
      FILL_SPOT,
      FILL_WHITE,
      FILL_BLACK
   } fill_kind_e;

   // DUT ports
   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   req_type               req_data;
   logic                  empty;
   logic                  pop;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   // Tracker state: a software copy of the core
   logic [CFG_W-1:0]     width_reg;
   logic [CFG_W-1:0]     height_reg;
   logic [PIXEL_W-1:0]   line_mem [WINDOW*MAX_WIDTH];
   logic [COL_SUM_W-1:0] col_sum [MAX_WIDTH];
   logic [COL_SUM_W-1:0] col_delay [WINDOW];
   logic [WIN_SUM_W-1:0] run_sum;
   int unsigned          col_cnt;
   int unsigned          row_cnt;
   logic [WIN_SUM_W-1:0] best_sum;
   logic                 best_found;
   int unsigned          best_x;
   int unsigned          best_y;

   rsp_type     frame_results_q [$];
   rsp_type     want;
   int unsigned results_made;
   int unsigned pixels_sent;
   int unsigned err_count;
   int unsigned pop_wait;
   bit          req_gaps_on;
   bit          rsp_gaps_on;

   brightest_window_locator_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Guard against a hung run
   initial begin
      #40_000_000;
      $display("tb_brightest_window_locator_core: errors");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tracker
   // ------------------------------------------------------------------------

   function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] r,
                                             input int unsigned top);
      if (r == 0) return 1;
      if (r > top) return top;
      return r;
   endfunction

   function automatic void forget_best();
      best_sum   = '0;
      best_found = 1'b0;
      best_x     = 0;
      best_y     = 0;
   endfunction

   // Advance the copy by one accepted pixel; queue a result at frame end
   function automatic void track_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
      int unsigned w, h, x, y, slot, cs, rs, d;
      rsp_type     res;
      w = clamp_dim(width_reg, MAX_WIDTH);
      h = clamp_dim(height_reg, MAX_HEIGHT);
      if (fs) begin
         col_cnt = 0;
         row_cnt = 0;
         forget_best();
      end
      x = (col_cnt >= MAX_WIDTH) ? MAX_WIDTH - 1 : col_cnt;
      y = (row_cnt >= MAX_HEIGHT) ? MAX_HEIGHT - 1 : row_cnt;

      // vertical sum over the last WINDOW rows
      slot = (y % WINDOW) * MAX_WIDTH + x;
      if (y == 0) begin
         cs = pix;
      end else begin
         cs = col_sum[x] + pix;
         if (y >= WINDOW) cs = cs - line_mem[slot];
      end
      cs = cs & ((1 << COL_SUM_W) - 1);
      line_mem[slot] = pix;
      col_sum[x] = COL_SUM_W'(cs);

      // horizontal sum over the last WINDOW column sums
      if (y + 1 >= WINDOW) begin
         d  = x % WINDOW;
         rs = (x == 0) ? cs : run_sum + cs;
         if (x >= WINDOW) rs = rs - col_delay[d];
         rs = rs & ((1 << WIN_SUM_W) - 1);
         col_delay[d] = COL_SUM_W'(cs);
         run_sum = WIN_SUM_W'(rs);
         // strictly greater only, so the earliest of equal windows stays
         if (x + 1 >= WINDOW && (!best_found || rs > best_sum)) begin
            best_found = 1'b1;
            best_sum   = WIN_SUM_W'(rs);
            best_x     = x + 1 - WINDOW;
            best_y     = y + 1 - WINDOW;
         end
      end

      // advance position; emit at the last pixel of the frame
      if (x + 1 >= w) begin
         col_cnt = 0;
         if (y + 1 >= h) begin
            res = '0;
            if (best_found) begin
               res.found      = 1'b1;
               res.corner_x   = COORD_W'(best_x);
               res.corner_y   = COORD_W'(best_y);
               res.centre_x   = COORD_W'(best_x + WINDOW / 2);
               res.centre_y   = COORD_W'(best_y + WINDOW / 2);
               res.window_sum = best_sum;
            end
            frame_results_q.push_back(res);
            results_made++;
            row_cnt = 0;
            forget_best();
         end else begin
            row_cnt = y + 1;
         end
      end else begin
         col_cnt = x + 1;
      end
   endfunction

   function automatic void check_field(input string name, input logic [31:0] exp,
                                       input logic [31:0] got);
      if (got !== exp) begin
         $error("%s: expected %0d, got %0d", name, exp, got);
         err_count++;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Result side
   // ------------------------------------------------------------------------

   // Drive pop with a random stall after each result
   initial begin
      pop      = 1'b0;
      pop_wait = 0;
      forever begin
         @(negedge clock);
         if (pop_wait != 0) begin
            pop <= 1'b0;
            pop_wait--;
         end else begin
            pop <= 1'b1;
         end
         @(posedge clock);
         if (pop && !empty) pop_wait = rsp_gaps_on ? $urandom_range(0, 4) : 0;
      end
   end

   // Compare each popped result with the oldest expected one
   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (frame_results_q.size() == 0) begin
            $error("unexpected result: found %0d, window_sum %0d",
                   rsp_data.found, rsp_data.window_sum);
            err_count++;
         end else begin
            want = frame_results_q.pop_front();
            check_field("found",      want.found,      rsp_data.found);
            check_field("corner_x",   want.corner_x,   rsp_data.corner_x);
            check_field("corner_y",   want.corner_y,   rsp_data.corner_y);
            check_field("centre_x",   want.centre_x,   rsp_data.centre_x);
            check_field("centre_y",   want.centre_y,   rsp_data.centre_y);
            check_field("window_sum", want.window_sum, rsp_data.window_sum);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side and CSR access
   // ------------------------------------------------------------------------

   task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input logic fs);
      int unsigned gap;
      gap = req_gaps_on ? $urandom_range(0, 4) : 0;
      repeat (gap) begin
         @(negedge clock);
         push <= 1'b0;
      end
      @(negedge clock);
      push                 <= 1'b1;
      req_data.pixel       <= pix;
      req_data.frame_start <= fs;
      do @(posedge clock); while (full);
      track_pixel(pix, fs);
      pixels_sent++;
   endtask

   // Send npix pixels of a frame w pixels wide, filled as asked
   task automatic send_frame(input int unsigned w, input int unsigned npix,
                             input fill_kind_e fill, input logic lead_fs);
      logic [PIXEL_W-1:0] base, pix;
      int unsigned        sx, sy, cx, cy;
      base = $urandom_range(0, 255);
      sx   = $urandom_range(0, w - 1);
      sy   = $urandom_range(0, (npix - 1) / w);
      for (int unsigned i = 0; i < npix; i++) begin
         cx = i % w;
         cy = i / w;
         case (fill)
            FILL_FLAT:  pix = base;
            FILL_DIM:   pix = $urandom_range(0, 3);
            FILL_WHITE: pix = 8'hFF;
            FILL_BLACK: pix = 8'h00;
            FILL_SPOT: begin
               if (cx >= sx && cx < sx + WINDOW && cy >= sy && cy < sy + WINDOW)
                  pix = $urandom_range(160, 255);
               else
                  pix = $urandom_range(0, 40);
            end
            default:    pix = $urandom_range(0, 255);
         endcase
         send_pixel(pix, (i == 0) ? lead_fs : 1'b0);
      end
   endtask

   // Hold requests until every expected result is back and the pipe is empty
   task automatic settle();
      @(negedge clock);
      push <= 1'b0;
      while (frame_results_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CFG_W-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == REG_IMAGE_WIDTH) width_reg = value;
      else height_reg = value;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read_check(input logic idx, input string name,
                                 input logic [CFG_W-1:0] exp);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      check_field(name, CSR_DATA_W'(exp), prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Change image size once idle, then read both registers back
   task automatic set_size(input int unsigned w, input int unsigned h);
      settle();
      csr_write(REG_IMAGE_WIDTH, CFG_W'(w));
      csr_write(REG_IMAGE_HEIGHT, CFG_W'(h));
      csr_read_check(REG_IMAGE_WIDTH, "image_width", CFG_W'(w));
      csr_read_check(REG_IMAGE_HEIGHT, "image_height", CFG_W'(h));
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   task automatic test_registers();
      csr_read_check(REG_IMAGE_WIDTH, "image_width", IMAGE_WIDTH_RST);
      csr_read_check(REG_IMAGE_HEIGHT, "image_height", IMAGE_HEIGHT_RST);
      set_size(2047, 2047);
      set_size(1024, 1024);
   endtask

   // Images smaller than the window: found stays clear
   task automatic test_small_images();
      // zero acts as one: every pixel is a whole frame
      set_size(0, 0);
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'h00, 1'b0);
      set_size(3, 2);
      send_frame(3, 6, FILL_NOISE, 1'b1);
      send_frame(3, 6, FILL_WHITE, 1'b0);
      // restart part way through a frame
      send_frame(3, 4, FILL_NOISE, 1'b1);
      send_frame(3, 6, FILL_FLAT, 1'b1);
      // one column short of a window
      set_size(WINDOW - 1, WINDOW);
      send_frame(WINDOW - 1, (WINDOW - 1) * WINDOW, FILL_NOISE, 1'b1);
   endtask

   // Oversized register values act as the maximum
   task automatic test_size_clamp();
      set_size(2047, 1);
      send_frame(MAX_WIDTH, MAX_WIDTH, FILL_NOISE, 1'b1);
      set_size(1, 1025);
      send_frame(1, MAX_HEIGHT, FILL_NOISE, 1'b1);
   endtask

   task automatic test_single_window();
      set_size(WINDOW, WINDOW);
      send_frame(WINDOW, WINDOW * WINDOW, FILL_WHITE, 1'b1);
      send_frame(WINDOW, WINDOW * WINDOW, FILL_BLACK, 1'b1);
      send_frame(WINDOW, WINDOW * WINDOW, FILL_NOISE, 1'b0);
   endtask

   // Flat frame, equal sums everywhere: the first window must be kept; then a dim frame
   task automatic test_ties();
      set_size(WINDOW + 7, WINDOW + 3);
      send_frame(WINDOW + 7, (WINDOW + 7) * (WINDOW + 3), FILL_FLAT, 1'b1);
      send_frame(WINDOW + 7, (WINDOW + 7) * (WINDOW + 3), FILL_DIM, 1'b1);
   endtask

   task automatic test_cut_short();
      int unsigned npix;
      npix = (WINDOW + 2) * (WINDOW + 1);
      set_size(WINDOW + 2, WINDOW + 1);
      // drop out before any window, then after the last row has begun
      send_frame(WINDOW + 2, npix / 2, FILL_NOISE, 1'b1);
      send_frame(WINDOW + 2, npix - 10, FILL_SPOT, 1'b1);
      send_frame(WINDOW + 2, npix, FILL_SPOT, 1'b1);
      send_frame(WINDOW + 2, npix, FILL_NOISE, 1'b0);
   endtask

   // Full-width frame, sent back to back
   task automatic test_widest_frame();
      set_size(MAX_WIDTH, WINDOW);
      req_gaps_on = 1'b0;
      send_frame(MAX_WIDTH, MAX_WIDTH * WINDOW, FILL_SPOT, 1'b1);
      req_gaps_on = 1'b1;
   endtask

   task automatic test_random_frames();
      int unsigned w, h, nframes, npix, results_base, pixels_base;
      logic        fs;
      results_base = results_made;
      pixels_base  = pixels_sent;
      while (results_made - results_base < 48 || pixels_sent - pixels_base < 900) begin
         // mostly small frames; now and then one large enough for windows
         if ($urandom_range(0, 3) == 0) begin
            w       = $urandom_range(WINDOW, WINDOW + 22);
            h       = $urandom_range(WINDOW, WINDOW + 8);
            nframes = $urandom_range(1, 2);
         end else begin
            w       = $urandom_range(1, 60);
            h       = $urandom_range(1, (300 / w > 1) ? 300 / w : 1);
            nframes = $urandom_range(1, 4);
         end
         set_size(w, h);
         repeat (nframes) begin
            req_gaps_on = ($urandom_range(0, 3) != 0);
            rsp_gaps_on = ($urandom_range(0, 3) != 0);
            // a frame left open must be restarted explicitly
            fs   = (col_cnt != 0 || row_cnt != 0) ? 1'b1 : 1'($urandom_range(0, 3) != 0);
            npix = w * h;
            if (npix > 1 && $urandom_range(0, 9) == 0) npix = $urandom_range(1, npix - 1);
            send_frame(w, npix, fill_kind_e'($urandom_range(0, 5)), fs);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      reset        = 1'b1;
      push         = 1'b0;
      req_data     = '0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      req_gaps_on  = 1'b1;
      rsp_gaps_on  = 1'b1;
      err_count    = 0;
      results_made = 0;
      pixels_sent  = 0;

      // tracker reset
      width_reg  = IMAGE_WIDTH_RST;
      height_reg = IMAGE_HEIGHT_RST;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (col_sum[i]) col_sum[i] = '0;
      foreach (col_delay[i]) col_delay[i] = '0;
      run_sum = '0;
      col_cnt = 0;
      row_cnt = 0;
      forget_best();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_registers();
      test_small_images();
      test_size_clamp();
      test_single_window();
      test_ties();
      test_cut_short();
      test_widest_frame();
      test_random_frames();

      // drain and let the pipe run dry
      @(negedge clock);
      push <= 1'b0;
      while (frame_results_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("tb_brightest_window_locator_core: clean");
      end else begin
         $display("tb_brightest_window_locator_core: errors");
      end
      $finish;
   end

endmodule
